### hdl/stsc_pkg.sv
// stsc_pkg: shared constants, types and helpers of the serial time-sync clock
// no dependencies
`timescale 1ns / 1ps

package stsc_pkg;

  localparam int LINE_CAPACITY = 32;
  localparam int FRAME_LENGTH  = 22;
  localparam int DATE_LENGTH   = 10;
  localparam int LEN_W         = $clog2(LINE_CAPACITY);
  localparam int IDX_W         = $clog2(FRAME_LENGTH);
  localparam int DATE_W        = 8 * DATE_LENGTH;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  localparam logic [7:0] HOURS_PER_DAY = 8'd24;
  localparam logic [7:0] UNITS_PER_MIN = 8'd60;
  localparam logic [5:0] LAST_UNIT     = 6'd59;
  localparam logic [4:0] LAST_HOUR     = 5'd23;

  // "2026-01-01", character 0 in the top byte
  localparam logic [DATE_W-1:0] RESET_DATE = 80'h32_30_32_36_2D_30_31_2D_30_31;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic              taken;
    logic [4:0]        hours;
    logic [5:0]        minutes;
    logic [5:0]        seconds;
    logic [DATE_W-1:0] date;
  } frame_t;

  typedef struct packed {
    logic [4:0]        hours;
    logic [5:0]        minutes;
    logic [5:0]        seconds;
    logic              synced;
    logic [DATE_W-1:0] date;
  } clock_t;

  function automatic logic [7:0] two_digit(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] h;
    logic [7:0] l;
    h = hi - CHAR_ZERO;
    l = lo - CHAR_ZERO;
    return (h << 3) + (h << 1) + l;
  endfunction

endpackage

### hdl/stsc_if.sv
// stsc_in_if, stsc_out_if: valid/ready channels of the serial time-sync clock
// no dependencies
`timescale 1ns / 1ps

interface stsc_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface stsc_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  hours;
  logic [5:0]  minutes;
  logic [5:0]  seconds;
  logic        synced;
  logic [39:0] date_head;
  logic [39:0] date_tail;
  logic        frame_taken;

  modport source (output valid, output hours, output minutes, output seconds,
                  output synced, output date_head, output date_tail,
                  output frame_taken, input ready);
  modport sink   (input valid, input hours, input minutes, input seconds,
                  input synced, input date_head, input date_tail,
                  input frame_taken, output ready);
endinterface

### hdl/stsc_line.sv
// stsc_line: received line store and time frame check
// depends on stsc_pkg
`timescale 1ns / 1ps

module stsc_line (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  stsc_pkg::item_t item_i,
  output stsc_pkg::frame_t frame_o
);
  import stsc_pkg::*;

  logic [7:0]       store_q [FRAME_LENGTH];
  logic [LEN_W-1:0] len_q, len_d;
  logic             is_byte, is_cr, is_lf, store_en, shape_ok, range_ok;
  logic [7:0]       h_val, m_val, s_val;

  assign is_byte  = step_i && (item_i.func == FUNC_BYTE);
  assign is_cr    = item_i.rx_byte == CHAR_CR;
  assign is_lf    = item_i.rx_byte == CHAR_LF;
  assign store_en = is_byte && !is_cr && !is_lf &&
                    (len_q < LEN_W'(LINE_CAPACITY - 1)) && (len_q < LEN_W'(FRAME_LENGTH));

  always_comb begin
    len_d = len_q;
    if (is_byte && !is_cr) begin
      if (is_lf) begin
        len_d = '0;
      end else if (len_q < LEN_W'(LINE_CAPACITY - 1)) begin
        len_d = len_q + LEN_W'(1);
      end else begin
        len_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      store_q[len_q[IDX_W-1:0]] <= item_i.rx_byte;
    end
  end

  assign shape_ok = (len_q == LEN_W'(FRAME_LENGTH)) &&
                    (store_q[0] == CHAR_T) && (store_q[1] == CHAR_COLON) &&
                    (store_q[6] == CHAR_DASH) && (store_q[9] == CHAR_DASH) &&
                    (store_q[12] == CHAR_SPACE) &&
                    (store_q[15] == CHAR_COLON) && (store_q[18] == CHAR_COLON);

  assign h_val    = two_digit(store_q[13], store_q[14]);
  assign m_val    = two_digit(store_q[16], store_q[17]);
  assign s_val    = two_digit(store_q[19], store_q[20]);
  assign range_ok = (h_val < HOURS_PER_DAY) && (m_val < UNITS_PER_MIN) &&
                    (s_val < UNITS_PER_MIN);

  always_comb begin
    frame_o.taken   = is_byte && is_lf && shape_ok && range_ok;
    frame_o.hours   = h_val[4:0];
    frame_o.minutes = m_val[5:0];
    frame_o.seconds = s_val[5:0];
    for (int i = 0; i < DATE_LENGTH; i++) begin
      frame_o.date[DATE_W-1-8*i -: 8] = store_q[2+i];
    end
  end

endmodule

### hdl/stsc_time.sv
// stsc_time: time of day counters, date and synced flag
// depends on stsc_pkg
`timescale 1ns / 1ps

module stsc_time (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tick_i,
  input  stsc_pkg::frame_t frame_i,
  output stsc_pkg::clock_t clock_d_o
);
  import stsc_pkg::*;

  clock_t clock_q, clock_d;

  always_comb begin
    clock_d = clock_q;
    if (frame_i.taken) begin
      clock_d.hours   = frame_i.hours;
      clock_d.minutes = frame_i.minutes;
      clock_d.seconds = frame_i.seconds;
      clock_d.date    = frame_i.date;
      clock_d.synced  = 1'b1;
    end else if (tick_i) begin
      if (clock_q.seconds < LAST_UNIT) begin
        clock_d.seconds = clock_q.seconds + 6'd1;
      end else begin
        clock_d.seconds = '0;
        if (clock_q.minutes < LAST_UNIT) begin
          clock_d.minutes = clock_q.minutes + 6'd1;
        end else begin
          clock_d.minutes = '0;
          clock_d.hours   = (clock_q.hours >= LAST_HOUR) ? 5'd0 : clock_q.hours + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q.hours   <= '0;
      clock_q.minutes <= '0;
      clock_q.seconds <= '0;
      clock_q.synced  <= 1'b0;
      clock_q.date    <= RESET_DATE;
    end else begin
      clock_q <= clock_d;
    end
  end

  assign clock_d_o = clock_d;

endmodule

### hdl/serial_time_sync_clock.sv
// serial_time_sync_clock: top level with input register and result register
// depends on stsc_pkg, stsc_if, stsc_line, stsc_time
//
// One item a cycle unless stalled: an item sits in the input register, where
// the line check and the clock update run, and its result moves to the result
// register; the input register lets one more item in while a result waits.
// Each item, byte or tick, gives exactly one result: the clock after the item,
// with frame_taken high when a line feed ended a valid "T:date time" line.
`timescale 1ns / 1ps

module serial_time_sync_clock (
  input logic        clk_i,
  input logic        rst_ni,
  stsc_in_if.sink    in_i,
  stsc_out_if.source out_o
);
  import stsc_pkg::*;

  item_t  item_q;
  logic   in_v_q;
  logic   out_v_q;
  logic   adv;
  clock_t clock_d;
  clock_t res_q;
  logic   taken_q;
  frame_t frame;

  assign adv        = in_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready = !in_v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_v_q <= in_i.valid;
      end
      if (adv) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.func    <= in_i.func;
      item_q.rx_byte <= in_i.rx_byte;
    end
    if (adv) begin
      res_q   <= clock_d;
      taken_q <= frame.taken;
    end
  end

  stsc_line u_line (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (adv),
    .item_i  (item_q),
    .frame_o (frame)
  );

  stsc_time u_time (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (adv && (item_q.func == FUNC_TICK)),
    .frame_i   (frame),
    .clock_d_o (clock_d)
  );

  assign out_o.valid       = out_v_q;
  assign out_o.hours       = res_q.hours;
  assign out_o.minutes     = res_q.minutes;
  assign out_o.seconds     = res_q.seconds;
  assign out_o.synced      = res_q.synced;
  assign out_o.date_head   = res_q.date[DATE_W-1 -: 40];
  assign out_o.date_tail   = res_q.date[39:0];
  assign out_o.frame_taken = taken_q;

  a_taken_synced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && taken_q |-> res_q.synced)
    else $error("frame taken without synced");

  a_time_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (res_q.hours < 5'd24) && (res_q.minutes < 6'd60) && (res_q.seconds < 6'd60))
    else $error("clock out of range");

  a_adv_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_v_q)
    else $error("result lost after advance");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_v_q && out_v_q && !out_o.ready)
    else $error("stall without full pipeline");

endmodule
